/* hdl/atcrq_pkg.sv */
// shared types, constants and keyword tables for the at command recognizer queue
// no dependencies
package atcrq_pkg;

    localparam int LINE_BUF_DEPTH_DEF = 64;
    localparam int QUEUE_DEPTH_DEF    = 16;

    localparam int CODE_W      = 4;
    localparam int BYTE_W      = 8;
    localparam int KW_COUNT    = 8;
    localparam int KW_MAX_LEN  = 5;
    localparam int KW_POS_W    = 3;

    typedef enum logic {
        REQ_BYTE = 1'b0,
        REQ_POP  = 1'b1
    } req_t;

    localparam logic [CODE_W-1:0] CMD_NONE  = 4'd0;
    localparam logic [CODE_W-1:0] CMD_ZERO  = 4'd8;

    localparam logic [BYTE_W-1:0] CHAR_NUL = 8'h00;
    localparam logic [BYTE_W-1:0] CHAR_NL  = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_A   = "A";
    localparam logic [BYTE_W-1:0] CHAR_T   = "T";

    localparam logic [KW_COUNT-1:0] ALL_ALIVE = '1;

    // keyword text after "AT", index k gives command code k+1
    localparam logic [BYTE_W-1:0] KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
        '{"O", "N", 8'h00, 8'h00, 8'h00},
        '{"O", "F", "F", 8'h00, 8'h00},
        '{"S", "T", "A", "T", "E"},
        '{"P", "R", "I", "N", "T"},
        '{"R", "E", "S", "E", "T"},
        '{"R", "E", "A", "D", 8'h00},
        '{"P", "O", "W", "E", "R"},
        '{"Z", "E", "R", "O", 8'h00}
    };

    localparam logic [KW_POS_W-1:0] KW_LEN [KW_COUNT] = '{
        3'd2, 3'd3, 3'd5, 3'd5, 3'd5, 3'd4, 3'd5, 3'd4
    };

    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] code;
    } push_t;

endpackage

/* hdl/atcrq_ram.sv */
// generic single write port, single read port ram with registered read
// write-first on a same-address collision; no dependencies
module atcrq_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (we && (waddr == raddr)) begin
            rdata_reg <= wdata;
        end else begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/atcrq_line_matcher.sv */
// streaming matcher for at command lines, one byte per step
// depends on atcrq_pkg
module atcrq_line_matcher #(
    parameter int LINE_BUF_DEPTH = atcrq_pkg::LINE_BUF_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              step,
    input  logic [atcrq_pkg::BYTE_W-1:0]      rx_byte,
    output atcrq_pkg::push_t                  push
);

    localparam int POS_W = $clog2(LINE_BUF_DEPTH);

    logic [POS_W-1:0]                    pos_reg, pos_next;
    logic                                prev_a_reg, prev_a_next;
    logic                                at_reg, at_next;
    logic                                trunc_reg, trunc_next;
    logic [atcrq_pkg::KW_POS_W-1:0]      kpos_reg, kpos_next;
    logic [atcrq_pkg::KW_COUNT-1:0]      alive_reg, alive_next;
    logic [atcrq_pkg::CODE_W-1:0]        matched_reg, matched_next;
    logic                                pos_last;

    assign pos_last = (pos_reg == POS_W'(LINE_BUF_DEPTH - 1));

    always_comb begin
        logic [atcrq_pkg::CODE_W-1:0] nl_code;
        pos_next     = pos_reg;
        prev_a_next  = prev_a_reg;
        at_next      = at_reg;
        trunc_next   = trunc_reg;
        kpos_next    = kpos_reg;
        alive_next   = alive_reg;
        matched_next = matched_reg;
        push         = '0;
        nl_code      = pos_last ? atcrq_pkg::CMD_NONE : matched_reg;
        if (step) begin
            if (rx_byte == atcrq_pkg::CHAR_NL) begin
                push.valid = (nl_code != atcrq_pkg::CMD_NONE);
                push.code  = nl_code;
            end else if (!(trunc_reg || (matched_reg != atcrq_pkg::CMD_NONE))) begin
                if (rx_byte == atcrq_pkg::CHAR_NUL) begin
                    trunc_next = 1'b1;
                end else if (!at_reg) begin
                    if (prev_a_reg && (rx_byte == atcrq_pkg::CHAR_T)) begin
                        at_next    = 1'b1;
                        kpos_next  = '0;
                        alive_next = atcrq_pkg::ALL_ALIVE;
                    end else begin
                        prev_a_next = (rx_byte == atcrq_pkg::CHAR_A);
                    end
                end else if ((alive_reg != '0) &&
                             (kpos_reg < atcrq_pkg::KW_POS_W'(atcrq_pkg::KW_MAX_LEN))) begin
                    for (int k = 0; k < atcrq_pkg::KW_COUNT; k++) begin
                        if (alive_reg[k]) begin
                            if (atcrq_pkg::KW_TEXT[k][kpos_reg] != rx_byte) begin
                                alive_next[k] = 1'b0;
                            end else if ((kpos_reg + 1'b1) == atcrq_pkg::KW_LEN[k]) begin
                                matched_next = atcrq_pkg::CODE_W'(k + 1);
                            end
                        end
                    end
                    kpos_next = kpos_reg + 1'b1;
                end
            end
            // newline or position wrap starts a fresh line
            if ((rx_byte == atcrq_pkg::CHAR_NL) || pos_last) begin
                pos_next     = '0;
                prev_a_next  = 1'b0;
                at_next      = 1'b0;
                trunc_next   = 1'b0;
                kpos_next    = '0;
                alive_next   = atcrq_pkg::ALL_ALIVE;
                matched_next = atcrq_pkg::CMD_NONE;
            end else begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            prev_a_reg  <= 1'b0;
            at_reg      <= 1'b0;
            trunc_reg   <= 1'b0;
            kpos_reg    <= '0;
            alive_reg   <= atcrq_pkg::ALL_ALIVE;
            matched_reg <= atcrq_pkg::CMD_NONE;
        end else begin
            pos_reg     <= pos_next;
            prev_a_reg  <= prev_a_next;
            at_reg      <= at_next;
            trunc_reg   <= trunc_next;
            kpos_reg    <= kpos_next;
            alive_reg   <= alive_next;
            matched_reg <= matched_next;
        end
    end

endmodule

/* hdl/atcrq_cmd_queue.sv */
// circular command queue, drops the oldest entry when full
// depends on atcrq_pkg and atcrq_ram
module atcrq_cmd_queue #(
    parameter int QUEUE_DEPTH = atcrq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  atcrq_pkg::push_t              push,
    input  logic                          pop,
    output logic [atcrq_pkg::CODE_W-1:0]  pop_code
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    logic [PTR_W-1:0]             head_reg, head_next;
    logic [PTR_W-1:0]             tail_reg, tail_next;
    logic [PTR_W-1:0]             head_inc, tail_inc;
    logic [PTR_W-1:0]             raddr;
    logic [atcrq_pkg::CODE_W-1:0] rdata;
    logic                         not_empty;

    assign head_inc  = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc  = (tail_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
    assign not_empty = (head_reg != tail_reg);

    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        if (push.valid) begin
            tail_next = tail_inc;
            if (tail_inc == head_reg) begin
                head_next = head_inc;
            end
        end else if (pop && not_empty) begin
            head_next = head_inc;
        end
    end

    // read data always tracks the entry at head
    assign raddr    = aresetn ? head_next : '0;
    assign pop_code = not_empty ? rdata : atcrq_pkg::CMD_NONE;

    atcrq_ram #(
        .WIDTH (atcrq_pkg::CODE_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (push.valid),
        .waddr (tail_reg),
        .wdata (push.code),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

endmodule

/* hdl/at_command_recognizer_queue_unit.sv */
// at command recognizer queue, top level: input register, line matcher, queue, result register
// depends on atcrq_pkg, atcrq_line_matcher, atcrq_cmd_queue
// throughput: one transaction per cycle; a pop waits while the previous result is not taken
// a pop result reaches m_tdata via the input register and then the result register
// reset: synchronous, clears line state and queue pointers; stored codes are not cleared
module at_command_recognizer_queue_unit #(
    parameter int LINE_BUF_DEPTH = atcrq_pkg::LINE_BUF_DEPTH_DEF,
    parameter int QUEUE_DEPTH    = atcrq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] rx_byte
    input  logic [0:0] s_tuser,   // [0] req_type
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [3:0] command_code, [7:4] zero
);

    logic                                 in_valid_reg, in_valid_next;
    atcrq_pkg::req_t                      in_req_reg;
    logic [atcrq_pkg::BYTE_W-1:0]         in_byte_reg;
    logic                                 out_valid_reg, out_valid_next;
    logic [atcrq_pkg::CODE_W-1:0]         out_code_reg;
    logic                                 s_accept;
    logic                                 fire;
    logic                                 byte_fire;
    logic                                 pop_fire;
    atcrq_pkg::push_t                     push;
    logic [atcrq_pkg::CODE_W-1:0]         pop_code;

    assign fire      = in_valid_reg &&
                       ((in_req_reg == atcrq_pkg::REQ_BYTE) || !out_valid_reg || m_tready);
    assign byte_fire = fire && (in_req_reg == atcrq_pkg::REQ_BYTE);
    assign pop_fire  = fire && (in_req_reg == atcrq_pkg::REQ_POP);
    assign s_tready  = !in_valid_reg || fire;
    assign s_accept  = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (pop_fire) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_req_reg  <= atcrq_pkg::req_t'(s_tuser[0]);
            in_byte_reg <= s_tdata;
        end
        if (pop_fire) begin
            out_code_reg <= pop_code;
        end
    end

    atcrq_line_matcher #(
        .LINE_BUF_DEPTH (LINE_BUF_DEPTH)
    ) u_matcher (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (byte_fire),
        .rx_byte (in_byte_reg),
        .push    (push)
    );

    atcrq_cmd_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .pop      (pop_fire),
        .pop_code (pop_code)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(8 - atcrq_pkg::CODE_W){1'b0}}, out_code_reg};

`ifndef NO_ASSERTIONS
    a_result_from_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(in_valid_reg && (in_req_reg == atcrq_pkg::REQ_POP)))
        else $error("result appeared without a pop transaction");

    a_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[3:0] <= atcrq_pkg::CMD_ZERO))
        else $error("command code out of range");

    a_bytes_never_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && (in_req_reg == atcrq_pkg::REQ_BYTE)) |-> s_tready)
        else $error("byte transaction stalled the input");

    a_no_push_on_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        pop_fire |-> !push.valid)
        else $error("push and pop in the same cycle");
`endif

endmodule

/* dv/atcrq_command_checker.sv */
// command checker for the at command recognizer queue: watches both stream channels,
// predicts each pop result from the received bytes and compares it field by field
// depends on atcrq_pkg
module atcrq_command_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] rx_byte
    input  logic [0:0] s_tuser,   // [0] req_type
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,   // [3:0] command_code, [7:4] zero
    output int         error_count,
    output int         pending_codes,
    output int         codes_seen,
    output int         commands_queued
);
    import atcrq_pkg::*;

    localparam int LINE_DEPTH  = LINE_BUF_DEPTH_DEF;
    localparam int STORE_DEPTH = QUEUE_DEPTH_DEF;

    string kw_text [KW_COUNT] = '{"ON", "OFF", "STATE", "PRINT", "RESET", "READ", "POWER", "ZERO"};

    int                line_len;
    bit                seen_a;
    bit                at_seen;
    bit                cut_off;
    int                kw_pos;
    logic [KW_COUNT-1:0] alive;
    logic [CODE_W-1:0] matched;
    logic [CODE_W-1:0] code_store [STORE_DEPTH];
    logic [3:0]        head;
    logic [3:0]        tail;
    logic [CODE_W-1:0] expected_codes [$];
    int                errors;
    int                results;
    int                pushes;

    task report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        errors++;
        $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
    endtask

    function void clear_line_state();
        line_len = 0;
        seen_a   = 0;
        at_seen  = 0;
        cut_off  = 0;
        kw_pos   = 0;
        alive    = ALL_ALIVE;
        matched  = CMD_NONE;
    endfunction

    function void feed_matcher(logic [7:0] c);
        int k;
        if (cut_off || matched != CMD_NONE)
            return;
        if (c == CHAR_NUL) begin
            cut_off = 1;
            return;
        end
        if (!at_seen) begin
            if (seen_a && c == CHAR_T) begin
                at_seen = 1;
                kw_pos  = 0;
                alive   = ALL_ALIVE;
            end else begin
                seen_a = (c == CHAR_A);
            end
            return;
        end
        if (alive == '0 || kw_pos >= KW_MAX_LEN)
            return;
        for (k = 0; k < KW_COUNT; k++) begin
            if (alive[k]) begin
                if (8'(kw_text[k][kw_pos]) != c)
                    alive[k] = 1'b0;
                else if (kw_pos + 1 == kw_text[k].len())
                    matched = CODE_W'(k + 1);
            end
        end
        kw_pos++;
    endfunction

    // one accepted input transaction; a pop queues its expected code
    function void recognize_transaction(logic req, logic [7:0] c);
        logic [CODE_W-1:0] code;
        if (req == REQ_POP) begin
            code = CMD_NONE;
            if (head != tail) begin
                code = code_store[head];
                head++;
            end
            expected_codes.push_back(code);
            return;
        end
        if (c == CHAR_NL) begin
            code = matched;
            if (line_len + 1 >= LINE_DEPTH)
                code = CMD_NONE;
            clear_line_state();
            if (code != CMD_NONE) begin
                code_store[tail] = code;
                tail++;
                if (tail == head)
                    head++;
                pushes++;
            end
            return;
        end
        feed_matcher(c);
        line_len++;
        if (line_len >= LINE_DEPTH)
            clear_line_state();
    endfunction

    always @(posedge aclk) begin
        logic [CODE_W-1:0] want;
        if (!aresetn) begin
            clear_line_state();
            head = '0;
            tail = '0;
            expected_codes.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                results++;
                if (expected_codes.size() == 0) begin
                    report_mismatch("unexpected result, code", m_tdata, 8'h00);
                end else begin
                    want = expected_codes.pop_front();
                    if (m_tdata[3:0] != want)
                        report_mismatch("command_code", {4'h0, m_tdata[3:0]}, {4'h0, want});
                    if (m_tdata[7:4] != 4'h0)
                        report_mismatch("tdata padding", {4'h0, m_tdata[7:4]}, 8'h00);
                end
            end
            if (s_tvalid && s_tready)
                recognize_transaction(s_tuser[0], s_tdata);
        end
        error_count     <= errors;
        pending_codes   <= expected_codes.size();
        codes_seen      <= results;
        commands_queued <= pushes;
    end

endmodule

/* dv/at_command_recognizer_queue_unit_tb.sv */
// testbench top for the at command recognizer queue: drives byte and pop transactions
// under several idle and stall mixes, gives the verdict from the command checker
// depends on atcrq_pkg, atcrq_command_checker, at_command_recognizer_queue_unit
module at_command_recognizer_queue_unit_tb;
    import atcrq_pkg::*;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata  = 8'h00;
    logic [0:0] s_tuser  = 1'b0;
    logic       m_tready = 1'b0;
    logic       s_tready;
    logic       m_tvalid;
    logic [7:0] m_tdata;

    int error_count;
    int pending_codes;
    int codes_seen;
    int commands_queued;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int pop_pct       = 15;
    int hold_request  = 0;
    int items_sent    = 0;
    int pops_sent     = 0;

    logic [7:0] line_bytes [$];
    string      keywords [KW_COUNT] = '{"ON", "OFF", "STATE", "PRINT", "RESET", "READ", "POWER", "ZERO"};

    at_command_recognizer_queue_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    atcrq_command_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .error_count     (error_count),
        .pending_codes   (pending_codes),
        .codes_seen      (codes_seen),
        .commands_queued (commands_queued)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // receiver: random stalls, or a long hold-off counted here
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    initial begin
        #3000000;
        $display("at_command_recognizer_queue_unit_tb: errors");
        $finish;
    end

    task automatic send_item(logic req, logic [7:0] c);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= c;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        if (req == REQ_POP)
            pops_sent++;
    endtask

    function void put_text(string s);
        for (int i = 0; i < s.len(); i++) line_bytes.push_back(8'(s[i]));
    endfunction

    function logic [7:0] pad_char();
        return 8'($urandom_range(8'h61, 8'h7a));
    endfunction

    task automatic flush_line();
        foreach (line_bytes[i]) send_item(REQ_BYTE, line_bytes[i]);
        line_bytes.delete();
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_codes != 0) @(posedge aclk);
    endtask

    task automatic random_line();
        int    kind;
        int    k;
        int    n;
        int    target;
        bit    tail_cmd;
        string kw;
        if ($urandom_range(99) < pop_pct) begin
            repeat ($urandom_range(1, 3)) send_item(REQ_POP, 8'($urandom_range(255)));
            return;
        end
        kind = $urandom_range(99);
        if (kind < 55) begin
            if ($urandom_range(3) == 0)
                repeat ($urandom_range(1, 3)) put_text(($urandom_range(1) == 1) ? "A" : "x");
            put_text("AT");
            k  = $urandom_range(KW_COUNT - 1);
            kw = keywords[k];
            n  = $urandom_range(1, kw.len() - 1);
            case ($urandom_range(9))
                0: put_text(kw.substr(0, kw.len() - 2));
                1: begin
                    put_text(kw.substr(0, n - 1));
                    line_bytes.push_back(CHAR_NUL);
                    put_text(kw.substr(n, kw.len() - 1));
                end
                2: begin
                    put_text(kw);
                    line_bytes.push_back(CHAR_NUL);
                    put_text("ATOFF");
                end
                3: begin
                    put_text(kw);
                    put_text("xyz");
                end
                4: begin
                    put_text("Q");
                    put_text("AT");
                    put_text(kw);
                end
                default: put_text(kw);
            endcase
            put_text("\n");
        end else if (kind < 65) begin
            // long lines around the line buffer depth
            case ($urandom_range(5))
                0: target = 62;
                1: target = 63;
                2: target = 64;
                3: target = 65;
                default: target = $urandom_range(40, 130);
            endcase
            tail_cmd = $urandom_range(1);
            if ($urandom_range(1) == 1)
                put_text("ATPOWER");
            while (line_bytes.size() < target - (tail_cmd ? 4 : 0))
                line_bytes.push_back(pad_char());
            if (tail_cmd)
                put_text("ATON");
            put_text("\n");
        end else if (kind < 80) begin
            repeat ($urandom_range(1, 10)) line_bytes.push_back(8'($urandom_range(255)));
            if ($urandom_range(1) == 1)
                put_text("\n");
        end else begin
            case ($urandom_range(6))
                0: put_text("AATSTATE\n");
                1: put_text("ATATON\n");
                2: put_text("AXATRESET\n");
                3: put_text("ATREADATZERO\n");
                4: put_text("ATOF\n");
                5: put_text("AT\n");
                default: put_text("\n");
            endcase
        end
        flush_line();
    endtask

    task automatic run_phase(int items, int idle, int stall, int pops);
        int start;
        start         = items_sent;
        send_idle_pct = idle;
        stall_pct     = stall;
        pop_pct       = pops;
        while (items_sent - start < items) random_line();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        send_item(REQ_POP, 8'hFF);
        put_text("ATON\n");
        put_text("ATO");
        line_bytes.push_back(CHAR_NUL);
        put_text("N\n");
        flush_line();
        repeat (3) send_item(REQ_POP, 8'h00);
        send_item(REQ_BYTE, 8'hFF);
        send_item(REQ_BYTE, 8'h80);
        send_item(REQ_BYTE, CHAR_NL);

        run_phase(60, 0, 0, 15);
        run_phase(60, 77, 0, 40);
        drain();
        run_phase(60, 0, 77, 15);
        hold_request = 400;
        run_phase(30, 0, 0, 70);
        run_phase(60, 18, 18, 30);
        run_phase(40, 0, 0, 50);

        drain();
        repeat (10) @(posedge aclk);
        $display("run covered %0d transactions (%0d pops), %0d results checked",
                 items_sent, pops_sent, codes_seen);
        $display("%0d commands were queued under idle, stall and hold-off mixes",
                 commands_queued);
        if (error_count == 0) begin
            $display("at_command_recognizer_queue_unit_tb: clean");
        end else begin
            $display("at_command_recognizer_queue_unit_tb: errors");
        end
        $finish;
    end

endmodule
